/* rtl/core/salc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants and codes for the set-associative LRU cache lookup block.
// ----------------------------------------------------------------------------
package salc_pkg;

   // default geometry
   localparam int DEF_NUM_SETS    = 64;
   localparam int DEF_NUM_WAYS    = 4;
   localparam int DEF_OFFSET_BITS = 5;

   // fixed field widths of the beats
   localparam int ADDR_W    = 64;
   localparam int SET_NUM_W = 6;
   localparam int WAY_NUM_W = 2;

   // access kind
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

endpackage

/* rtl/core/salc_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_req_if
// Access channel: one read or write to a byte address per beat.
// ----------------------------------------------------------------------------
interface salc_req_if;
   import salc_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output command, output address, input ready);
   modport sink   (input valid, input command, input address, output ready);

endinterface

/* rtl/core/salc_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_rsp_if
// Result channel: hit, write-back flag, set and way of one access per beat.
// ----------------------------------------------------------------------------
interface salc_rsp_if;
   import salc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic                 dirty_eviction;
   logic [SET_NUM_W-1:0] set_number;
   logic [WAY_NUM_W-1:0] way_used;

   modport source (output valid, output hit, output dirty_eviction, output set_number,
                   output way_used, input ready);
   modport sink   (input valid, input hit, input dirty_eviction, input set_number,
                   input way_used, output ready);

endinterface

/* rtl/core/set_assoc_lru_cache_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Tag lookup and LRU replacement state of a set-associative write-back cache.
// ----------------------------------------------------------------------------
// Takes one access beat per clock unless the result side holds it off, and
// returns one result beat per access, in order, after a registered set read
// and a compare and update into the result register. Tags,
// dirty, valid and rank state of a set sit together in one row of a
// single-port-write, registered-read memory; an access to the set that was
// updated in the cycle before is served from a forwarding register. After
// reset a clearing pass writes each of the 2**floor(log2(NUM_SETS)) rows
// (64 at the defaults), one per cycle; req_bus.ready stays
// low until it is done.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup #(
   parameter int NUM_SETS    = salc_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS    = salc_pkg::DEF_NUM_WAYS,
   parameter int OFFSET_BITS = salc_pkg::DEF_OFFSET_BITS
) (
   input logic          clock,
   input logic          reset,
   salc_req_if.sink     req_bus,
   salc_rsp_if.source   rsp_bus
);
   import salc_pkg::*;

   localparam int INDEX_BITS = $clog2(NUM_SETS + 1) - 1;
   localparam int SET_W      = (INDEX_BITS > 0) ? INDEX_BITS : 1;
   localparam int SET_ROWS   = 1 << INDEX_BITS;
   localparam int SHIFT      = OFFSET_BITS + INDEX_BITS;
   localparam int TAG_W      = ADDR_W - SHIFT;
   localparam int WAY_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int RANK_W     = WAY_W;
   localparam logic [RANK_W-1:0] RANK_TOP  = RANK_W'(NUM_WAYS - 1);
   localparam logic [SET_W-1:0]  LAST_ROW  = SET_W'(SET_ROWS - 1);

   typedef struct packed {
      logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
      logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
      logic [NUM_WAYS-1:0]             valid;
      logic [NUM_WAYS-1:0]             dirty;
   } row_type;

   function automatic row_type reset_row();
      row_type r;
      r = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r.rank[w] = RANK_W'(w);
      end
      return r;
   endfunction

   // address split
   logic [SET_W-1:0] req_set;
   logic [TAG_W-1:0] req_tag;

   assign req_tag = req_bus.address[ADDR_W-1:SHIFT];

   if (INDEX_BITS > 0) begin : g_index
      assign req_set = req_bus.address[OFFSET_BITS +: SET_W];
   end else begin : g_no_index
      assign req_set = '0;
   end

   // handshake
   logic clr_ff;
   logic [SET_W-1:0] clr_idx_ff;
   logic stg_valid_ff;
   logic out_valid_ff;
   logic out_free;
   logic stg_fire;
   logic req_fire;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign stg_fire      = stg_valid_ff && out_free;
   assign req_bus.ready = !clr_ff && (!stg_valid_ff || stg_fire);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_ROW) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // lookup stage registers
   logic             stg_cmd_ff;
   logic [TAG_W-1:0] stg_tag_ff;
   logic [SET_W-1:0] stg_set_ff;
   logic             fwd_ff;
   row_type          last_row_ff;

   // set state memory
   row_type row_mem [SET_ROWS];
   row_type rd_row_ff;
   row_type new_row;

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         row_mem[clr_idx_ff] <= reset_row();
      end else if (stg_fire) begin
         row_mem[stg_set_ff] <= new_row;
      end
      if (req_fire) begin
         rd_row_ff <= row_mem[req_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         if (req_fire) begin
            stg_valid_ff <= 1'b1;
            fwd_ff       <= stg_fire && (stg_set_ff == req_set);
         end else if (stg_fire) begin
            stg_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_cmd_ff <= req_bus.command;
         stg_tag_ff <= req_tag;
         stg_set_ff <= req_set;
      end
      if (stg_fire) begin
         last_row_ff <= new_row;
      end
   end

   // compare, victim choice and rank update
   row_type             cur_row;
   logic [NUM_WAYS-1:0] match;
   logic                hit;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    victim;
   logic [WAY_W-1:0]    way_sel;
   logic [RANK_W-1:0]   used_rank;
   logic                evict;

   always_comb begin
      cur_row = fwd_ff ? last_row_ff : rd_row_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         match[w] = cur_row.valid[w] && (cur_row.tag[w] == stg_tag_ff);
      end
      hit = |match;

      // lowest matching way wins
      hit_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
      end

      // least recently used way holds rank zero
      victim = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (cur_row.rank[w] == '0) begin
            victim = WAY_W'(w);
         end
      end

      way_sel   = hit ? hit_way : victim;
      used_rank = cur_row.rank[way_sel];
      evict     = !hit && cur_row.valid[way_sel] && cur_row.dirty[way_sel];

      new_row = cur_row;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (WAY_W'(w) == way_sel) begin
            new_row.rank[w] = RANK_TOP;
         end else if (cur_row.rank[w] > used_rank) begin
            new_row.rank[w] = cur_row.rank[w] - 1'b1;
         end
      end

      if (hit) begin
         if (stg_cmd_ff == CMD_WRITE) begin
            new_row.dirty[way_sel] = 1'b1;
         end
      end else begin
         new_row.valid[way_sel] = 1'b1;
         new_row.tag[way_sel]   = stg_tag_ff;
         new_row.dirty[way_sel] = (stg_cmd_ff == CMD_WRITE);
      end
   end

   // result register
   logic                 out_hit_ff;
   logic                 out_evict_ff;
   logic [SET_NUM_W-1:0] out_set_ff;
   logic [WAY_NUM_W-1:0] out_way_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stg_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_fire) begin
         out_hit_ff   <= hit;
         out_evict_ff <= evict;
         out_set_ff   <= SET_NUM_W'(stg_set_ff);
         out_way_ff   <= WAY_NUM_W'(way_sel);
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.hit            = out_hit_ff;
   assign rsp_bus.dirty_eviction = out_evict_ff;
   assign rsp_bus.set_number     = out_set_ff;
   assign rsp_bus.way_used       = out_way_ff;

endmodule

/* rtl/core/salc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks for the cache lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit,
   input logic rsp_dirty_eviction
);
   import salc_pkg::*;

   // beats taken but not yet delivered
   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready) begin
         pend_in = pend_in + 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         pend_in = pend_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // a hit never asks for a write-back
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_dirty_eviction)
      else $error("write-back flagged on a hit");

   // every result beat belongs to an access taken earlier, at most two in flight
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0) && (pend_ff != 2'd3))
      else $error("result beat without an outstanding access");

   // the access channel is not ready when reset has just been released
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("access taken before the clearing pass");

endmodule

bind set_assoc_lru_cache_lookup salc_checker u_salc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_hit            (rsp_bus.hit),
   .rsp_dirty_eviction (rsp_bus.dirty_eviction)
);

/* tb/salc_lookup_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_lookup_checker
// Watches the access and result channels of the cache lookup block, keeps
// its own copy of the tag, valid, dirty and rank state, predicts the result
// of every accepted access and compares result beats against it in order.
// ----------------------------------------------------------------------------
module salc_lookup_checker (
   input  logic clock,
   input  logic reset,
   salc_req_if  req_mon,
   salc_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   outstanding,
   output int   result_total,
   output int   hit_total,
   output int   writeback_total
);
   import salc_pkg::*;

   localparam int NUM_SETS = DEF_NUM_SETS;
   localparam int NUM_WAYS = DEF_NUM_WAYS;
   localparam int OFFSET_W = DEF_OFFSET_BITS;
   // floor(log2) of the set count
   localparam int INDEX_W  = $clog2(NUM_SETS + 1) - 1;
   localparam int TAG_W    = ADDR_W - INDEX_W - OFFSET_W;
   localparam int RANK_W   = WAY_NUM_W;

   typedef struct packed {
      logic                 hit;
      logic                 dirty_eviction;
      logic [SET_NUM_W-1:0] set_number;
      logic [WAY_NUM_W-1:0] way_used;
   } lookup_result_type;

   typedef struct {
      lookup_result_type res;
      logic              command;
      logic [ADDR_W-1:0] address;
   } pending_access_type;

   // model copy of the line state
   logic              line_valid [NUM_SETS][NUM_WAYS];
   logic              line_dirty [NUM_SETS][NUM_WAYS];
   logic [TAG_W-1:0]  line_tag   [NUM_SETS][NUM_WAYS];
   logic [RANK_W-1:0] line_rank  [NUM_SETS][NUM_WAYS];

   pending_access_type expected_lookups [$];

   int n_mismatch;
   int n_results;
   int n_hits;
   int n_writebacks;

   // look up one access, update the line state and return its result
   function automatic lookup_result_type predict_lookup(input logic cmd,
                                                        input logic [ADDR_W-1:0] addr);
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] old_rank;
      lookup_result_type res;
      logic              found;
      int                set_idx;
      int                way;
      int                victim;
      int                w;

      tag     = addr[ADDR_W-1 -: TAG_W];
      set_idx = (INDEX_W == 0) ? 0 : int'(addr[OFFSET_W +: INDEX_W]);
      found   = 1'b0;
      way     = 0;
      victim  = 0;

      // lowest matching valid way wins; rank zero marks the victim
      for (w = 0; w < NUM_WAYS; w++) begin
         if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
            found = 1'b1;
            way   = w;
         end
         if (line_rank[set_idx][w] == '0)
            victim = w;
      end

      res.hit            = found;
      res.dirty_eviction = 1'b0;
      if (found) begin
         if (cmd == CMD_WRITE)
            line_dirty[set_idx][way] = 1'b1;
      end else begin
         way                = victim;
         res.dirty_eviction = line_valid[set_idx][way] && line_dirty[set_idx][way];
         line_valid[set_idx][way] = 1'b1;
         line_tag[set_idx][way]   = tag;
         line_dirty[set_idx][way] = (cmd == CMD_WRITE);
      end

      // ranks above the used way drop by one, used way becomes most recent
      old_rank = line_rank[set_idx][way];
      for (w = 0; w < NUM_WAYS; w++) begin
         if (line_rank[set_idx][w] > old_rank)
            line_rank[set_idx][w] = line_rank[set_idx][w] - 1'b1;
      end
      line_rank[set_idx][way] = RANK_W'(NUM_WAYS - 1);

      res.set_number = SET_NUM_W'(set_idx);
      res.way_used   = WAY_NUM_W'(way);
      return res;
   endfunction

   // compare result beats, then record new access beats
   always @(posedge clock) begin
      pending_access_type head;
      pending_access_type item;
      lookup_result_type  got;
      int                 s;
      int                 w;

      if (reset) begin
         for (s = 0; s < NUM_SETS; s++) begin
            for (w = 0; w < NUM_WAYS; w++) begin
               line_valid[s][w] = 1'b0;
               line_dirty[s][w] = 1'b0;
               line_tag[s][w]   = '0;
               line_rank[s][w]  = RANK_W'(w);
            end
         end
         expected_lookups.delete();
         n_mismatch   = 0;
         n_results    = 0;
         n_hits       = 0;
         n_writebacks = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{hit: rsp_mon.hit, dirty_eviction: rsp_mon.dirty_eviction,
                    set_number: rsp_mon.set_number, way_used: rsp_mon.way_used};
            n_results++;
            if (got.hit === 1'b1)
               n_hits++;
            if (got.dirty_eviction === 1'b1)
               n_writebacks++;
            if (expected_lookups.size() == 0) begin
               if (n_mismatch < 10) begin
                  $display("%0t: result beat with no access waiting", $realtime);
                  $display("   got hit=%b wb=%b set=%0d way=%0d",
                           got.hit, got.dirty_eviction, got.set_number, got.way_used);
               end
               n_mismatch++;
            end else begin
               head = expected_lookups.pop_front();
               if (got !== head.res) begin
                  if (n_mismatch < 10) begin
                     $display("%0t: mismatch cmd=%0d addr=%h", $realtime,
                              head.command, head.address);
                     $display("   exp hit=%b wb=%b set=%0d way=%0d",
                              head.res.hit, head.res.dirty_eviction,
                              head.res.set_number, head.res.way_used);
                     $display("   got hit=%b wb=%b set=%0d way=%0d",
                              got.hit, got.dirty_eviction, got.set_number,
                              got.way_used);
                  end
                  n_mismatch++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            item.command = req_mon.command;
            item.address = req_mon.address;
            item.res     = predict_lookup(req_mon.command, req_mon.address);
            expected_lookups.insert(expected_lookups.size(), item);
         end
      end

      mismatch_count  <= n_mismatch;
      outstanding     <= expected_lookups.size();
      result_total    <= n_results;
      hit_total       <= n_hits;
      writeback_total <= n_writebacks;
   end

endmodule

/* tb/set_assoc_lru_cache_lookup_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_tb
// Drives directed and random read/write accesses into the cache lookup block
// with random idling on both channels and one long result stall; a checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_tb;
   import salc_pkg::*;

   localparam int INDEX_W      = $clog2(DEF_NUM_SETS + 1) - 1;
   localparam int OFFSET_W     = DEF_OFFSET_BITS;
   localparam int TAG_W        = ADDR_W - INDEX_W - OFFSET_W;
   localparam int POOL_SIZE    = 6;
   localparam int PHASE_ITEMS  = 480;
   localparam int HOLD_AT      = 600;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 100000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   salc_req_if req_bus ();
   salc_rsp_if rsp_bus ();

   int send_idle_pct = 23;
   int recv_idle_pct = 56;
   int accepted      = 0;
   int cycle_count   = 0;
   bit hold_done     = 1'b0;

   logic [TAG_W-1:0] tag_pool [POOL_SIZE];

   int mismatches;
   int outstanding;
   int results;
   int hits;
   int writebacks;

   always #5 clock = ~clock;

   set_assoc_lru_cache_lookup u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   salc_lookup_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatch_count  (mismatches),
      .outstanding     (outstanding),
      .result_total    (results),
      .hit_total       (hits),
      .writeback_total (writebacks)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off once enough beats went in
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && accepted >= HOLD_AT) begin
            repeat (LONG_HOLD) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
            hold_done = 1'b1;
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input int set_idx, input int offset);
      return {tag, INDEX_W'(set_idx), OFFSET_W'(offset)};
   endfunction

   // offer one access beat and wait for it to be taken
   task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      accepted++;
   endtask

   // mostly a few hot sets and a small tag pool so lines hit and get evicted
   task automatic random_access();
      logic              cmd;
      logic [ADDR_W-1:0] addr;
      int                pick;
      int                set_idx;

      cmd  = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      pick = $urandom_range(99);
      if (pick < 15) begin
         addr = {$urandom, $urandom};
      end else begin
         if (pick < 70)
            set_idx = $urandom_range(3) * 21;
         else
            set_idx = $urandom_range(DEF_NUM_SETS - 1);
         addr = make_addr(tag_pool[$urandom_range(POOL_SIZE - 1)], set_idx,
                          $urandom_range((1 << OFFSET_W) - 1));
      end
      send_access(cmd, addr);
   endtask

   initial begin
      logic [63:0] seed_bits;
      int          phase;
      int          i;

      req_bus.valid   = 1'b0;
      req_bus.command = CMD_READ;
      req_bus.address = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero tag must miss on invalid lines, then hit at any offset
      send_access(CMD_READ,  make_addr('0, 0, 0));
      send_access(CMD_READ,  make_addr('0, 0, 31));
      send_access(CMD_WRITE, make_addr('0, 0, 16));
      // all-ones address: top set, top tag
      send_access(CMD_READ,  '1);
      send_access(CMD_WRITE, '1);
      // single-bit addresses at the field edges
      send_access(CMD_READ,  64'h8000_0000_0000_0000);
      send_access(CMD_WRITE, 64'h0000_0000_0000_0800);
      send_access(CMD_READ,  64'h0000_0000_0000_0400);
      send_access(CMD_WRITE, make_addr(TAG_W'(3), 0, 1));
      // set 0 full: touch way 0, then replace clean, dirty, dirty, dirty, dirty in rank order
      send_access(CMD_READ,  make_addr('0, 0, 7));
      send_access(CMD_WRITE, make_addr(TAG_W'(5), 0, 2));
      send_access(CMD_READ,  make_addr(TAG_W'(7), 0, 3));
      send_access(CMD_READ,  make_addr(TAG_W'(1), 0, 4));
      send_access(CMD_READ,  make_addr(TAG_W'(3), 0, 5));
      send_access(CMD_WRITE, make_addr(TAG_W'(9), 0, 6));
      // evicted lines come back as misses
      send_access(CMD_READ,  make_addr('0, 0, 0));
      send_access(CMD_READ,  64'h8000_0000_0000_0000);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // fresh tag pool each phase, keeping the all-zero and all-ones tags
         tag_pool[0] = '0;
         tag_pool[1] = '1;
         for (i = 2; i < POOL_SIZE; i++) begin
            seed_bits   = {$urandom, $urandom};
            tag_pool[i] = seed_bits[TAG_W-1:0];
         end
         repeat (PHASE_ITEMS) random_access();
      end
      req_bus.valid <= 1'b0;

      // wait for every predicted result, then a little longer for strays
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d accesses: %0d hits, %0d misses, %0d dirty write-backs",
               results, hits, results - hits, writebacks);
      $display("idling on both channels in three mixes, one %0d-cycle result stall",
               LONG_HOLD);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
